### design/awac_pkg.sv
`default_nettype none
package awac_pkg;

   localparam int NUM_WINDOWS = 8;
   localparam int IDX_W = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

   localparam int ADDR_W = 64;
   localparam int LEN_W = 41;
   localparam int END_W = ADDR_W + 1;
   localparam int OFF_W = 40;
   localparam int SLOT_W = 3;
   localparam int STATUS_W = 3;
   localparam int CMD_W = 2;

   localparam logic [LEN_W-1:0] MAX_TRANSFER_RESET = LEN_W'(1048576);

   localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UNREGISTER = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BADLEN = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DENIED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OVERLAP = 3'd5;

   typedef struct packed {
      logic             load;
      logic             scan;
      logic [IDX_W-1:0] idx;
      logic             commit_pre;
      logic             commit_final;
   } dp_cmd_type;

   typedef struct packed {
      logic pre_fail;
   } dp_stat_type;

endpackage
`default_nettype wire

### design/awac_ctrl.sv
`default_nettype none
module awac_ctrl
   import awac_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd,
   output logic             busy
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PREP = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             last_slot;

   assign last_slot = (idx_ff == IDX_W'(NUM_WINDOWS - 1));
   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cmd = '0;
      cmd.idx = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            idx_in = '0;
            if (stat.pre_fail) begin
               cmd.commit_pre = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (last_slot) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DONE: begin
            cmd.commit_final = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire

### design/awac_dp.sv
`default_nettype none
module awac_dp
   import awac_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   output dp_stat_type              stat,
   input  wire logic [CMD_W-1:0]    req_command,
   input  wire logic [ADDR_W-1:0]   req_address,
   input  wire logic [LEN_W-1:0]    req_length,
   input  wire logic                csr_wr_en,
   input  wire logic [LEN_W-1:0]    csr_wr_data,
   output logic                     rsp_strobe,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [SLOT_W-1:0]        rsp_slot,
   output logic [OFF_W-1:0]         rsp_offset
);

   // request word
   logic [CMD_W-1:0]  cmd_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [END_W-1:0]  end_ff;

   logic [LEN_W-1:0]  max_transfer_ff;
   logic              enabled_ff;

   // window table
   logic [NUM_WINDOWS-1:0] valid_ff;
   logic [ADDR_W-1:0]      base_mem [NUM_WINDOWS];
   logic [END_W-1:0]       end_mem [NUM_WINDOWS];

   // scan results
   logic              found_ff;
   logic              ovl_ff;
   logic [IDX_W-1:0]  hit_ff;
   logic [OFF_W-1:0]  off_ff;

   logic                rsp_strobe_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [OFF_W-1:0]    rsp_offset_ff;

   logic                len_bad;
   logic                end_over;
   logic [STATUS_W-1:0] pre_code;
   logic                pre_fail;

   logic                ent_valid;
   logic [ADDR_W-1:0]   ent_base;
   logic [END_W-1:0]    ent_end;
   logic                ge_base;
   logic                meet;
   logic                match_now;

   logic [STATUS_W-1:0] fin_code;

   // length, end-address and enable checks
   assign len_bad = (len_ff == '0) || (len_ff > max_transfer_ff);
   assign end_over = end_ff[END_W-1];

   always_comb begin
      pre_fail = 1'b0;
      pre_code = ST_OK;
      case (cmd_ff)
         CMD_REGISTER: begin
            if (len_bad) begin
               pre_fail = 1'b1;
               pre_code = ST_BADLEN;
            end
         end
         CMD_CHECK: begin
            if (!enabled_ff) begin
               pre_fail = 1'b1;
               pre_code = ST_DENIED;
            end else if (len_bad || end_over) begin
               pre_fail = 1'b1;
               pre_code = ST_BADLEN;
            end
         end
         default: begin
            pre_fail = 1'b0;
         end
      endcase
   end

   assign stat.pre_fail = pre_fail;

   // one slot per cycle
   assign ent_valid = valid_ff[cmd.idx];
   assign ent_base = base_mem[cmd.idx];
   assign ent_end = end_mem[cmd.idx];
   assign ge_base = (addr_ff >= ent_base);
   assign meet = ge_base ? ({1'b0, addr_ff} < ent_end) : ({1'b0, ent_base} < end_ff);

   always_comb begin
      case (cmd_ff)
         CMD_REGISTER:   match_now = !ent_valid;
         CMD_UNREGISTER: match_now = ent_valid && (ent_base == addr_ff);
         CMD_CHECK:      match_now = ent_valid && ge_base && (end_ff <= ent_end);
         CMD_LOOKUP:     match_now = ent_valid && ge_base && ({1'b0, addr_ff} < ent_end);
         default:        match_now = 1'b0;
      endcase
   end

   always_comb begin
      fin_code = ST_OK;
      case (cmd_ff)
         CMD_REGISTER: begin
            if (!found_ff) begin
               fin_code = ST_FULL;
            end else if (ovl_ff) begin
               fin_code = ST_OVERLAP;
            end
         end
         CMD_CHECK: begin
            if (!found_ff) begin
               fin_code = ST_DENIED;
            end
         end
         default: begin
            if (!found_ff) begin
               fin_code = ST_NOTFOUND;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_command;
         addr_ff <= req_address;
         len_ff <= req_length;
         end_ff <= {1'b0, req_address} + END_W'(req_length);
      end
      if (cmd.scan && match_now && !found_ff) begin
         hit_ff <= cmd.idx;
         off_ff <= addr_ff[OFF_W-1:0] - ent_base[OFF_W-1:0];
      end
      if (cmd.commit_final && (fin_code == ST_OK) && (cmd_ff == CMD_REGISTER)) begin
         base_mem[hit_ff] <= addr_ff;
         end_mem[hit_ff] <= end_ff;
      end
      if (cmd.commit_pre) begin
         rsp_status_ff <= pre_code;
         rsp_slot_ff <= '0;
         rsp_offset_ff <= '0;
      end else if (cmd.commit_final) begin
         rsp_status_ff <= fin_code;
         if (fin_code == ST_OK) begin
            rsp_slot_ff <= SLOT_W'(hit_ff);
            if ((cmd_ff == CMD_CHECK) || (cmd_ff == CMD_LOOKUP)) begin
               rsp_offset_ff <= off_ff;
            end else begin
               rsp_offset_ff <= '0;
            end
         end else begin
            rsp_slot_ff <= '0;
            rsp_offset_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_transfer_ff <= MAX_TRANSFER_RESET;
         enabled_ff <= 1'b0;
         valid_ff <= '0;
         found_ff <= 1'b0;
         ovl_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_transfer_ff <= csr_wr_data;
         end
         if (cmd.load) begin
            found_ff <= 1'b0;
            ovl_ff <= 1'b0;
         end else if (cmd.scan) begin
            if (match_now) begin
               found_ff <= 1'b1;
            end
            if (ent_valid && meet) begin
               ovl_ff <= 1'b1;
            end
         end
         if (cmd.commit_final && (fin_code == ST_OK)) begin
            if (cmd_ff == CMD_REGISTER) begin
               valid_ff[hit_ff] <= 1'b1;
               enabled_ff <= 1'b1;
            end else if (cmd_ff == CMD_UNREGISTER) begin
               valid_ff[hit_ff] <= 1'b0;
            end
         end
         rsp_strobe_ff <= cmd.commit_pre || cmd.commit_final;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot = rsp_slot_ff;
   assign rsp_offset = rsp_offset_ff;

endmodule
`default_nettype wire

### design/address_window_access_checker.sv
// a word refused on its length, end address or enable state answers with rsp_strobe from the PREP state
// any other word scans the window table one slot per cycle and answers from the DONE state
// a new word is taken only in the idle state, once the last word is through
// the receiver cannot stall; every word gives exactly one result
// synchronous reset empties the table, clears the enable and restores max_transfer
`default_nettype none
module address_window_access_checker
   import awac_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [CMD_W-1:0]    req_command,
   input  wire logic [ADDR_W-1:0]   req_address,
   input  wire logic [LEN_W-1:0]    req_length,
   output logic                     rsp_strobe,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [SLOT_W-1:0]        rsp_slot,
   output logic [OFF_W-1:0]         rsp_offset,
   input  wire logic                csr_wr_en,
   input  wire logic [LEN_W-1:0]    csr_wr_data
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   awac_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (dp_stat),
      .cmd   (dp_cmd),
      .busy  (busy)
   );

   awac_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dp_cmd),
      .stat        (dp_stat),
      .req_command (req_command),
      .req_address (req_address),
      .req_length  (req_length),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_status  (rsp_status),
      .rsp_slot    (rsp_slot),
      .rsp_offset  (rsp_offset)
   );

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result word while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not make the block busy");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two result words in a row");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ST_OK)) |-> ((rsp_slot == '0) && (rsp_offset == '0)))
      else $error("failed word carries slot or offset");

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import awac_pkg::*;

   typedef enum logic [1:0] {ENTRY_WORD, ENTRY_CSR, ENTRY_DRAIN} entry_kind_type;

   typedef struct {
      entry_kind_type    kind;
      logic [CMD_W-1:0]  cmd;
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  len;
      int                gap;
   } backlog_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [OFF_W-1:0]    offset;
   } reply_type;

   localparam logic [LEN_W-1:0] LEN_ALL_ONES = {LEN_W{1'b1}};
   localparam logic [LEN_W-1:0] LEN_TOP_BIT = {1'b1, {OFF_W{1'b0}}};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [CMD_W-1:0]    req_command = CMD_REGISTER;
   logic [ADDR_W-1:0]   req_address = '0;
   logic [LEN_W-1:0]    req_length = '0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [OFF_W-1:0]    rsp_offset;
   logic                csr_wr_en = 1'b0;
   logic [LEN_W-1:0]    csr_wr_data = '0;

   address_window_access_checker dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .req_address (req_address),
      .req_length  (req_length),
      .rsp_strobe  (rsp_strobe),
      .rsp_status  (rsp_status),
      .rsp_slot    (rsp_slot),
      .rsp_offset  (rsp_offset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // window table as the block should hold it
   logic              win_valid [NUM_WINDOWS];
   logic [ADDR_W-1:0] win_base [NUM_WINDOWS];
   logic [LEN_W-1:0]  win_size [NUM_WINDOWS];
   logic              checker_armed = 1'b0;
   logic [LEN_W-1:0]  xfer_cap = MAX_TRANSFER_RESET;

   backlog_type       word_backlog [$];
   reply_type         awaited_replies [$];
   logic [ADDR_W-1:0] known_bases [$];

   int   gap_left = 0;
   logic gap_served = 1'b0;
   logic stimulus_done = 1'b0;
   logic calm = 1'b0;
   int   words_sent = 0;
   int   replies_seen = 0;
   int   csr_writes = 0;
   int   mismatches = 0;

   initial begin
      for (int w = 0; w < NUM_WINDOWS; w++) begin
         win_valid[w] = 1'b0;
         win_base[w] = '0;
         win_size[w] = '0;
      end
   end

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic reply_type window_verdict(input logic [CMD_W-1:0] cmd,
                                                input logic [ADDR_W-1:0] addr,
                                                input logic [LEN_W-1:0] len);
      reply_type         v;
      int                hit;
      logic [ADDR_W-1:0] len64;
      logic [ADDR_W-1:0] size64;
      logic [ADDR_W-1:0] d;
      v.status = ST_OK;
      v.slot = '0;
      v.offset = '0;
      hit = -1;
      len64 = ADDR_W'(len);
      case (cmd)
         CMD_REGISTER: begin
            if (len == '0 || len > xfer_cap) begin
               v.status = ST_BADLEN;
            end else begin
               for (int w = NUM_WINDOWS - 1; w >= 0; w--) begin
                  if (!win_valid[w]) hit = w;
               end
               if (hit < 0) begin
                  v.status = ST_FULL;
               end else begin
                  for (int w = 0; w < NUM_WINDOWS; w++) begin
                     size64 = ADDR_W'(win_size[w]);
                     if (win_valid[w]) begin
                        if (addr >= win_base[w]) begin
                           if (addr - win_base[w] < size64) v.status = ST_OVERLAP;
                        end else if (win_base[w] - addr < len64) begin
                           v.status = ST_OVERLAP;
                        end
                     end
                  end
                  if (v.status == ST_OK) begin
                     win_valid[hit] = 1'b1;
                     win_base[hit] = addr;
                     win_size[hit] = len;
                     checker_armed = 1'b1;
                     v.slot = SLOT_W'(hit);
                  end
               end
            end
         end
         CMD_UNREGISTER: begin
            for (int w = NUM_WINDOWS - 1; w >= 0; w--) begin
               if (win_valid[w] && win_base[w] == addr) hit = w;
            end
            if (hit < 0) begin
               v.status = ST_NOTFOUND;
            end else begin
               win_valid[hit] = 1'b0;
               v.slot = SLOT_W'(hit);
            end
         end
         CMD_CHECK: begin
            if (!checker_armed) begin
               v.status = ST_DENIED;
            end else if (len == '0 || len > xfer_cap || len64 > ~addr) begin
               v.status = ST_BADLEN;
            end else begin
               for (int w = 0; w < NUM_WINDOWS; w++) begin
                  size64 = ADDR_W'(win_size[w]);
                  d = addr - win_base[w];
                  if (hit < 0 && win_valid[w] && addr >= win_base[w]
                      && d <= size64 && len64 <= size64 - d) hit = w;
               end
               if (hit < 0) begin
                  v.status = ST_DENIED;
               end else begin
                  v.slot = SLOT_W'(hit);
                  v.offset = OFF_W'(addr - win_base[hit]);
               end
            end
         end
         CMD_LOOKUP: begin
            for (int w = 0; w < NUM_WINDOWS; w++) begin
               size64 = ADDR_W'(win_size[w]);
               if (hit < 0 && win_valid[w] && addr >= win_base[w]
                   && addr - win_base[w] < size64) hit = w;
            end
            if (hit < 0) begin
               v.status = ST_NOTFOUND;
            end else begin
               v.slot = SLOT_W'(hit);
               v.offset = OFF_W'(addr - win_base[hit]);
            end
         end
      endcase
      return v;
   endfunction

   task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                  input logic [ADDR_W-1:0] want);
      mismatches++;
      $display("tb: reply %0d: %s got %0h want %0h", replies_seen, what, got, want);
   endtask

   task automatic queue_entry(input entry_kind_type kind, input logic [CMD_W-1:0] cmd,
                              input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
      backlog_type e;
      e.kind = kind;
      e.cmd = cmd;
      e.addr = addr;
      e.len = len;
      e.gap = 0;
      if (!calm && $urandom_range(0, 3) == 0) e.gap = $urandom_range(1, 12);
      word_backlog.push_back(e);
   endtask

   function automatic logic [LEN_W-1:0] pick_len(input logic [LEN_W-1:0] cap);
      logic [LEN_W-1:0] l;
      case ($urandom_range(0, 19))
         0: l = '0;
         1: l = cap;
         2: l = cap + 1'b1;
         3: l = LEN_W'({$urandom, $urandom});
         default: l = LEN_W'($urandom_range(1, 64));
      endcase
      return l;
   endfunction

   function automatic logic [ADDR_W-1:0] pick_addr(input logic [ADDR_W-1:0] region);
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] b;
      int                k;
      k = $urandom_range(0, 9);
      if (known_bases.size() > 0) b = known_bases[$urandom_range(0, known_bases.size() - 1)];
      if (k == 0) begin
         a = {$urandom, $urandom};
      end else if (known_bases.size() == 0) begin
         a = region + ADDR_W'($urandom_range(0, 1023));
      end else if (k == 1) begin
         a = b + ADDR_W'(LEN_W'({$urandom, $urandom}));
      end else begin
         a = b + ADDR_W'($urandom_range(0, 80));
      end
      return a;
   endfunction

   task automatic random_phase(input logic [LEN_W-1:0] cap, input int count, input logic last);
      logic [ADDR_W-1:0] region;
      logic [ADDR_W-1:0] a;
      int                drain_at;
      int                r;
      calm = last || $urandom_range(0, 3) == 0;
      foreach (known_bases[i])
         queue_entry(ENTRY_WORD, CMD_UNREGISTER, known_bases[i], LEN_W'({$urandom, $urandom}));
      known_bases.delete();
      queue_entry(ENTRY_CSR, CMD_REGISTER, '0, cap);
      case ($urandom_range(0, 3))
         0: region = '0;
         1: region = {ADDR_W{1'b1}} - ADDR_W'(2047);
         default: region = {$urandom, $urandom};
      endcase
      drain_at = $urandom_range(10, count - 1);
      for (int i = 0; i < count; i++) begin
         if (i == drain_at) queue_entry(ENTRY_DRAIN, CMD_REGISTER, '0, '0);
         r = $urandom_range(0, 99);
         if (r < 5) begin
            queue_entry(ENTRY_WORD, CMD_W'($urandom), {$urandom, $urandom},
                        LEN_W'({$urandom, $urandom}));
         end else if (r < 35) begin
            a = region + ADDR_W'($urandom_range(0, 31) * 32);
            known_bases.push_back(a);
            queue_entry(ENTRY_WORD, CMD_REGISTER, a, pick_len(cap));
         end else if (r < 50) begin
            if (known_bases.size() > 0 && $urandom_range(0, 3) != 0)
               a = known_bases[$urandom_range(0, known_bases.size() - 1)];
            else
               a = pick_addr(region);
            queue_entry(ENTRY_WORD, CMD_UNREGISTER, a, LEN_W'({$urandom, $urandom}));
         end else if (r < 80) begin
            queue_entry(ENTRY_WORD, CMD_CHECK, pick_addr(region), pick_len(cap));
         end else begin
            queue_entry(ENTRY_WORD, CMD_LOOKUP, pick_addr(region), pick_len(cap));
         end
      end
   endtask

   // sender side
   always @(posedge clock) begin : word_driver
      logic        nx_start;
      logic        nx_csr;
      logic        idle;
      backlog_type head;
      if (!reset) begin
         nx_start = start;
         nx_csr = 1'b0;
         if (start && !busy) begin
            awaited_replies.push_back(window_verdict(req_command, req_address, req_length));
            words_sent++;
            nx_start = 1'b0;
         end
         idle = awaited_replies.size() == 0 && !rsp_strobe && !busy;
         if (!nx_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (word_backlog.size() > 0) begin
               head = word_backlog[0];
               case (head.kind)
                  ENTRY_WORD: begin
                     if (!gap_served && head.gap > 0) begin
                        gap_left = head.gap - 1;
                        gap_served = 1'b1;
                     end else begin
                        req_command <= head.cmd;
                        req_address <= head.addr;
                        req_length <= head.len;
                        nx_start = 1'b1;
                        gap_served = 1'b0;
                        word_backlog.delete(0);
                     end
                  end
                  ENTRY_CSR: begin
                     if (idle) begin
                        csr_wr_data <= head.len;
                        nx_csr = 1'b1;
                        xfer_cap = head.len;
                        csr_writes++;
                        word_backlog.delete(0);
                     end
                  end
                  ENTRY_DRAIN: begin
                     if (idle) word_backlog.delete(0);
                  end
                  default: begin
                     word_backlog.delete(0);
                  end
               endcase
            end else begin
               stimulus_done <= 1'b1;
            end
         end
         start <= nx_start;
         csr_wr_en <= nx_csr;
      end
   end

   // receiver side
   always @(posedge clock) begin : reply_check
      reply_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_replies.size() == 0) begin
            report_mismatch("word with nothing awaited, status", ADDR_W'(rsp_status), '0);
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", ADDR_W'(rsp_status), ADDR_W'(want.status));
            if (rsp_slot !== want.slot)
               report_mismatch("slot", ADDR_W'(rsp_slot), ADDR_W'(want.slot));
            if (rsp_offset !== want.offset)
               report_mismatch("offset", ADDR_W'(rsp_offset), ADDR_W'(want.offset));
         end
         replies_seen++;
      end
   end

   initial begin : run_ctrl
      logic [LEN_W-1:0] caps [8];
      int               counts [8];

      // directed part, reset max_transfer
      queue_entry(ENTRY_WORD, CMD_CHECK, 64'h0, 41'h1);
      queue_entry(ENTRY_WORD, CMD_LOOKUP, 64'h0, 41'h0);
      queue_entry(ENTRY_WORD, CMD_UNREGISTER, 64'h0, 41'h0);
      queue_entry(ENTRY_WORD, CMD_REGISTER, 64'h1000, 41'h0);
      queue_entry(ENTRY_WORD, CMD_REGISTER, 64'h1000, MAX_TRANSFER_RESET + 1'b1);
      queue_entry(ENTRY_WORD, CMD_REGISTER, 64'h1000, 41'h100);
      queue_entry(ENTRY_WORD, CMD_REGISTER, 64'h10f0, 41'h20);
      queue_entry(ENTRY_WORD, CMD_REGISTER, 64'h0f80, 41'h100);
      // window running past the top of the address space
      queue_entry(ENTRY_WORD, CMD_REGISTER, 64'hffff_ffff_ffff_ffc0, MAX_TRANSFER_RESET);
      queue_entry(ENTRY_WORD, CMD_LOOKUP, 64'hffff_ffff_ffff_ffff, 41'h0);
      queue_entry(ENTRY_WORD, CMD_CHECK, 64'hffff_ffff_ffff_ffc0, 41'h40);
      queue_entry(ENTRY_WORD, CMD_CHECK, 64'hffff_ffff_ffff_ffc0, 41'h41);
      queue_entry(ENTRY_WORD, CMD_CHECK, 64'h1000, 41'h100);
      queue_entry(ENTRY_WORD, CMD_CHECK, 64'h10ff, 41'h2);
      queue_entry(ENTRY_WORD, CMD_CHECK, 64'h1000, 41'h0);
      queue_entry(ENTRY_DRAIN, CMD_REGISTER, '0, '0);
      for (int i = 0; i < 6; i++)
         queue_entry(ENTRY_WORD, CMD_REGISTER, ADDR_W'(32'h2000 + i * 256), 41'h100);
      queue_entry(ENTRY_WORD, CMD_REGISTER, 64'h9000, 41'h10);
      queue_entry(ENTRY_WORD, CMD_UNREGISTER, 64'h1000, 41'h0);
      queue_entry(ENTRY_WORD, CMD_LOOKUP, 64'h1000, 41'h0);
      queue_entry(ENTRY_WORD, CMD_UNREGISTER, 64'hffff_ffff_ffff_ffc0, 41'h0);
      for (int i = 0; i < 6; i++)
         queue_entry(ENTRY_WORD, CMD_UNREGISTER, ADDR_W'(32'h2000 + i * 256), 41'h0);
      // empty table, enable must stay set
      queue_entry(ENTRY_WORD, CMD_CHECK, 64'h1000, 41'h0);

      caps[0] = 41'd256;
      caps[1] = '0;
      caps[2] = 41'd1;
      caps[3] = LEN_ALL_ONES;
      caps[4] = LEN_TOP_BIT;
      caps[5] = LEN_W'($urandom_range(16, 4096));
      caps[6] = LEN_W'({$urandom, $urandom});
      caps[7] = MAX_TRANSFER_RESET;
      foreach (counts[i]) counts[i] = (i == 1) ? 30 : 70;
      for (int p = 0; p < 8; p++) random_phase(caps[p], counts[p], p == 7);

      do @(posedge clock);
      while (!(stimulus_done && awaited_replies.size() == 0 && !rsp_strobe && !busy));
      repeat (NUM_WINDOWS + 4) @(posedge clock);
      if (awaited_replies.size() != 0)
         report_mismatch("words never answered, count", ADDR_W'(awaited_replies.size()), '0);
      $display("tb: %0d words sent, %0d answers compared, %0d max_transfer settings",
               words_sent, replies_seen, csr_writes);
      $display("tb: %0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
